>>> design/quarter_hour_chime_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Quarter-hour chime scheduler: assertion macros
// Concurrent checks clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUARTER_HOUR_CHIME_SCHEDULER_ASSERT_SVH
`define QUARTER_HOUR_CHIME_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define QHCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QHCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/qhcs_pkg.sv
// ----------------------------------------------------------------------------
// Quarter-hour chime scheduler package
// Codes, register indexes and the structs passed between the top level and
// the scheduling core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qhcs_pkg;

  // Series / play kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_HOURLY  = 2'd1;
  localparam logic [1:0] KIND_QUARTER = 2'd2;

  // Status codes
  localparam logic [2:0] ST_NOTHING   = 3'd0;
  localparam logic [2:0] ST_SCHEDULED = 3'd1;
  localparam logic [2:0] ST_REPLACED  = 3'd2;
  localparam logic [2:0] ST_SOUND_OFF = 3'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;

  // Item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_START = 2'd1;
  localparam logic [1:0] CFG_IDX_END   = 2'd2;

  localparam logic [2:0] MODE_RESET  = 3'd0;
  localparam logic [4:0] START_RESET = 5'd0;
  localparam logic [4:0] END_RESET   = 5'd24;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 5;

  typedef struct packed {
    logic [2:0] chime_mode;
    logic [4:0] window_start_hour;
    logic [4:0] window_end_hour;
  } qhcs_cfg_t;

  typedef struct packed {
    logic [1:0]  series_kind;
    logic [3:0]  series_count;
    logic        mark_valid;
    logic [15:0] last_quarter_mark;
  } qhcs_state_t;

  typedef struct packed {
    logic       func;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [8:0] day_of_year;
    logic       sound_on;
    logic       audio_task_running;
    logic       audio_busy;
    logic       play_accepted;
  } qhcs_item_t;

  typedef struct packed {
    logic [1:0] play_kind;
    logic       wake_audio;
    logic [2:0] status;
    logic [1:0] pending_type;
    logic [3:0] pending_left;
    logic       active_now;
  } qhcs_result_t;

endpackage

`default_nettype wire

>>> design/quarter_hour_chime_scheduler.sv
// Path: a transaction accepted into the input register goes through the core
//   into the result register, from which it is offered on m_axis.
// Throughput: one tick or poll per cycle unless m_axis stalls; the series
//   state is read and written in the single step between the two registers.
// Reset: synchronous, active low; clears both stages, the series state, the
//   quarter mark and the registers (mode 0, window 0 to 24).
// ----------------------------------------------------------------------------
// Quarter-hour chime scheduler
// Schedules hourly strikes and quarter chimes from time ticks and hands them
// out one at a time on audio service polls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quarter_hour_chime_scheduler_assert.svh"

module quarter_hour_chime_scheduler (
  input  wire                              clk,
  input  wire                              rst_n,
  // s_axis input: tdata = second, minute, hour, day_of_year, sound_on,
  //   audio_task_running, audio_busy, play_accepted (from bit 0 up)
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [qhcs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                              in_tuser,   // func
  // m_axis result: tdata = play_kind, wake_audio, status, pending_type,
  //   pending_left, active_now (from bit 0 up)
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [qhcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // register writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [1:0]                        cfg_index,
  input  wire [qhcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qhcs_pkg::*;

  qhcs_cfg_t    cfg_r;
  qhcs_state_t  state_r;
  qhcs_state_t  state_nxt;
  qhcs_item_t   item_r;
  qhcs_item_t   item_nxt;
  qhcs_result_t result;
  logic         s1_valid_r;
  logic         out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic         out_adv;
  logic         s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chime_mode        <= MODE_RESET;
      cfg_r.window_start_hour <= START_RESET;
      cfg_r.window_end_hour   <= END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MODE:  cfg_r.chime_mode        <= cfg_data[2:0];
        CFG_IDX_START: cfg_r.window_start_hour <= cfg_data;
        CFG_IDX_END:   cfg_r.window_end_hour   <= cfg_data;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // Result register frees up when empty or when taken
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  assign item_nxt.func               = in_tuser;
  assign item_nxt.second             = in_tdata[5:0];
  assign item_nxt.minute             = in_tdata[11:6];
  assign item_nxt.hour               = in_tdata[16:12];
  assign item_nxt.day_of_year        = in_tdata[25:17];
  assign item_nxt.sound_on           = in_tdata[26];
  assign item_nxt.audio_task_running = in_tdata[27];
  assign item_nxt.audio_busy         = in_tdata[28];
  assign item_nxt.play_accepted      = in_tdata[29];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  qhcs_core u_core (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Commit the series state only when the transaction moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {3'b000, result.active_now, result.pending_left, result.pending_type,
                     result.status, result.wake_audio, result.play_kind};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `QHCS_ASSERT_IMP(a_kind_count_agree, 1'b1,
    ((state_r.series_kind == KIND_NONE) == (state_r.series_count == 4'd0)) &&
    (state_r.series_kind != 2'd3), "series kind and count disagree")
  `QHCS_ASSERT_NXT(a_stage_moves, s1_adv, out_valid_r,
    "input stage advanced but no result was loaded")
  `QHCS_ASSERT_IMP(a_sched_active,
    out_valid_r && (out_data_r[5:3] == ST_SCHEDULED || out_data_r[5:3] == ST_REPLACED),
    out_data_r[12], "series scheduled outside an active hour")
  `QHCS_ASSERT_IMP(a_play_status,
    out_valid_r && (out_data_r[1:0] != KIND_NONE),
    (out_data_r[5:3] == ST_NOTHING) || (out_data_r[5:3] == ST_REFUSED),
    "chime requested with an inconsistent status")

endmodule

`default_nettype wire

>>> design/qhcs_core.sv
// ----------------------------------------------------------------------------
// Quarter-hour chime scheduler: scheduling core
// Combinational step: from one item, the registers and the current series
// state, work out the result and the next series state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qhcs_core (
  input  qhcs_pkg::qhcs_cfg_t    cfg,
  input  qhcs_pkg::qhcs_state_t  state,
  input  qhcs_pkg::qhcs_item_t   item,
  output qhcs_pkg::qhcs_state_t  state_nxt,
  output qhcs_pkg::qhcs_result_t result
);
  import qhcs_pkg::*;

  logic [4:0]  h24;
  logic [4:0]  h12;
  logic        win_ok;
  logic        mode_ok;
  logic        on;
  logic        min_bound;
  logic [2:0]  qtr;
  logic [15:0] mark;
  logic        boundary;
  logic        new_quarter;
  logic        start;
  logic [1:0]  start_kind;
  logic [3:0]  start_cnt;
  logic        have_series;

  // Hour folded to a day and to a clock face
  assign h24 = (item.hour >= 5'd24) ? item.hour - 5'd24 : item.hour;

  always_comb begin
    if (item.hour >= 5'd24) begin
      h12 = item.hour - 5'd24;
    end else if (item.hour >= 5'd12) begin
      h12 = item.hour - 5'd12;
    end else begin
      h12 = item.hour;
    end
    if (h12 == 5'd0) begin
      h12 = 5'd12;
    end
  end

  always_comb begin
    if (cfg.window_start_hour > 5'd24 || cfg.window_end_hour > 5'd24) begin
      win_ok = 1'b1;
    end else if (cfg.window_start_hour == 5'd0 && cfg.window_end_hour == 5'd24) begin
      win_ok = 1'b1;
    end else if (cfg.window_start_hour == cfg.window_end_hour) begin
      win_ok = 1'b0;
    end else if (cfg.window_start_hour < cfg.window_end_hour) begin
      win_ok = (h24 >= cfg.window_start_hour) && (h24 < cfg.window_end_hour);
    end else begin
      win_ok = (h24 >= cfg.window_start_hour) || (h24 < cfg.window_end_hour);
    end
  end

  assign mode_ok = (cfg.chime_mode == 3'd1) || (cfg.chime_mode == 3'd2) ||
                   (cfg.chime_mode == 3'd4);
  assign on      = mode_ok && win_ok;

  // Quarter index of the minute; only multiples of fifteen are boundaries
  always_comb begin
    case (item.minute)
      6'd0: begin
        min_bound = 1'b1;
        qtr       = 3'd0;
      end
      6'd15: begin
        min_bound = 1'b1;
        qtr       = 3'd1;
      end
      6'd30: begin
        min_bound = 1'b1;
        qtr       = 3'd2;
      end
      6'd45: begin
        min_bound = 1'b1;
        qtr       = 3'd3;
      end
      6'd60: begin
        min_bound = 1'b1;
        qtr       = 3'd4;
      end
      default: begin
        min_bound = 1'b0;
        qtr       = 3'd0;
      end
    endcase
  end

  // day * 96 + hour * 4 + quarter
  assign mark = ({7'd0, item.day_of_year} << 6) + ({7'd0, item.day_of_year} << 5) +
                {9'd0, item.hour, 2'b00} + {13'd0, qtr};

  assign boundary    = (item.func == FUNC_TICK) && (item.second == 6'd0) && min_bound;
  assign new_quarter = boundary &&
                       !(state.mark_valid && (mark == state.last_quarter_mark));

  always_comb begin
    start      = 1'b0;
    start_kind = KIND_NONE;
    start_cnt  = 4'd0;
    if (new_quarter && on) begin
      if (item.minute == 6'd0) begin
        start      = 1'b1;
        start_kind = KIND_HOURLY;
        start_cnt  = h12[3:0];
      end else if (cfg.chime_mode == 3'd2 && item.minute == 6'd30) begin
        start      = 1'b1;
        start_kind = KIND_QUARTER;
        start_cnt  = 4'd1;
      end else if (cfg.chime_mode == 3'd4) begin
        start_kind = KIND_QUARTER;
        case (item.minute)
          6'd15: begin
            start     = 1'b1;
            start_cnt = 4'd1;
          end
          6'd30: begin
            start     = 1'b1;
            start_cnt = 4'd2;
          end
          6'd45: begin
            start     = 1'b1;
            start_cnt = 4'd3;
          end
          default: begin
            start     = 1'b0;
            start_cnt = 4'd0;
          end
        endcase
      end
    end
  end

  assign have_series = (state.series_count != 4'd0) &&
                       ((state.series_kind == KIND_HOURLY) ||
                        (state.series_kind == KIND_QUARTER));

  always_comb begin
    state_nxt         = state;
    result.play_kind  = KIND_NONE;
    result.wake_audio = 1'b0;
    result.status     = ST_NOTHING;
    result.active_now = 1'b0;
    if (item.func == FUNC_TICK) begin
      result.active_now = on;
      if (new_quarter) begin
        state_nxt.mark_valid        = 1'b1;
        state_nxt.last_quarter_mark = mark;
      end
      if (start) begin
        result.status          = (state.series_count != 4'd0) ? ST_REPLACED : ST_SCHEDULED;
        state_nxt.series_kind  = start_kind;
        state_nxt.series_count = start_cnt;
      end
    end else if (have_series) begin
      if (!item.sound_on) begin
        state_nxt.series_kind  = KIND_NONE;
        state_nxt.series_count = 4'd0;
        result.status          = ST_SOUND_OFF;
      end else begin
        result.wake_audio = !item.audio_task_running;
        if (!item.audio_busy) begin
          result.play_kind = state.series_kind;
          if (item.play_accepted) begin
            state_nxt.series_count = state.series_count - 4'd1;
            if (state.series_count == 4'd1) begin
              state_nxt.series_kind = KIND_NONE;
            end
          end else begin
            state_nxt.series_kind  = KIND_NONE;
            state_nxt.series_count = 4'd0;
            result.status          = ST_REFUSED;
          end
        end
      end
    end
    result.pending_type = state_nxt.series_kind;
    result.pending_left = state_nxt.series_count;
  end

endmodule

`default_nettype wire
